[rtl/core/graph_layout_force_accumulator_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the force accumulator
// Concurrent checks that are removed from synthesis builds.
// ----------------------------------------------------------------------------
`ifndef GRAPH_LAYOUT_FORCE_ACCUMULATOR_ASSERT_SVH
`define GRAPH_LAYOUT_FORCE_ACCUMULATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define GFA_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error("check failed");
`define GFA_NEVER(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(prop)) else $error("check failed");
`else
`define GFA_ASSERT(lbl, ck, rn, prop)
`define GFA_NEVER(lbl, ck, rn, prop)
`endif
`endif

[rtl/core/gfa_pkg.sv]
// ----------------------------------------------------------------------------
// Force accumulator package
// Request and result types, register indexes, operation codes and states.
// ----------------------------------------------------------------------------
package gfa_pkg;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_EDGE = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} gfa_op_t;

	typedef enum logic [1:0] {
		REG_NODE_COUNT   = 2'd0,
		REG_GRAVITY_GAIN = 2'd1,
		REG_AREA_SIZE    = 2'd2,
		REG_ATTRACT_GAIN = 2'd3
	} gfa_reg_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [9:0]         node_a;
		logic [9:0]         node_b;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
	} gfa_req_t;

	typedef struct packed {
		logic [9:0]         node_index;
		logic signed [31:0] gravity_x;
		logic signed [31:0] gravity_y;
		logic signed [31:0] attract_x;
		logic signed [31:0] attract_y;
	} gfa_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_NORM,
		ST_SQX,
		ST_SQY,
		ST_SUM,
		ST_SQRT,
		ST_DIV,
		ST_MUL,
		ST_EMIT,
		ST_FRD_A,
		ST_FADD_A,
		ST_FRD_B,
		ST_FADD_B
	} gfa_state_t;

endpackage

[rtl/core/graph_layout_force_accumulator.sv]
// ----------------------------------------------------------------------------
// Graph layout force accumulator
// Per-node positions and attraction sums in block memories; unit-vector
// forces computed by a shared normalize, square-root and divide sequencer.
// ----------------------------------------------------------------------------
// One request is handled at a time. A load is written straight from the idle state;
// a read or an edge passes through the normalize shifts, the square root and the
// divider, and a zero-length vector skips the arithmetic. The square root runs
// 32 iterations, one result bit a cycle, and the divider FRAC_BITS + 1 quotient
// bits, one a cycle; an edge then does a read/modify/write of the force memory for
// both endpoints. A result waits in an output register; the next request is taken
// meanwhile, and a read stalls in its emit state while that register is full and
// res_stall is high.
module graph_layout_force_accumulator #(
	parameter int MAX_NODES = 1024,
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  gfa_pkg::gfa_req_t cmd,
	output logic              res_valid,
	input  logic              res_stall,
	output gfa_pkg::gfa_rsp_t res,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [30:0]       cfg_data
);
	import gfa_pkg::*;
`include "graph_layout_force_accumulator_assert.svh"

	localparam int AW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
	localparam int IW = (AW > 10) ? AW : 10;
	localparam logic [16:0] NODES_LIM = 17'(MAX_NODES);
	localparam int QW = FRAC_BITS + 1;
	localparam int PW = QW + 31;
	localparam logic [5:0] SQRT_STEPS = 6'd32;
	localparam logic [5:0] DIV_STEPS = 6'(QW);

	// config
	logic [10:0] node_count_q;
	logic [30:0] gravity_gain_q, area_size_q, attract_gain_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q   <= 11'd1024;
			gravity_gain_q <= 31'd65536;
			area_size_q    <= 31'd65536;
			attract_gain_q <= 31'd65536;
		end else if (cfg_valid && cfg_ready) begin
			unique case (gfa_reg_t'(cfg_index))
				REG_NODE_COUNT:   node_count_q   <= cfg_data[10:0];
				REG_GRAVITY_GAIN: gravity_gain_q <= cfg_data;
				REG_AREA_SIZE:    area_size_q    <= cfg_data;
				REG_ATTRACT_GAIN: attract_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// memories: {x, y}
	logic [63:0] pos_mem [MAX_NODES];
	logic [63:0] frc_mem [MAX_NODES];
	logic [63:0] pos_rdata, frc_rdata;
	logic [AW-1:0] pos_raddr, frc_raddr, frc_waddr;
	logic [63:0] frc_wdata;
	logic frc_we, pos_we;

	gfa_state_t state_q, state_d;
	gfa_req_t req_q;

	logic cmd_acc;
	logic a_ok, b_ok;
	logic [IW-1:0] a_ext, qa_ext, qb_ext;
	logic [AW-1:0] a_in, qa, qb;

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_acc = cmd_valid && !cmd_stall;
	assign a_ext = IW'(cmd.node_a);
	assign qa_ext = IW'(req_q.node_a);
	assign qb_ext = IW'(req_q.node_b);
	assign a_in = a_ext[AW-1:0];
	assign qa = qa_ext[AW-1:0];
	assign qb = qb_ext[AW-1:0];
	assign a_ok = ({1'b0, cmd.node_a} < node_count_q) && (17'(cmd.node_a) < NODES_LIM);
	assign b_ok = ({1'b0, cmd.node_b} < node_count_q) && (17'(cmd.node_b) < NODES_LIM);

	always_ff @(posedge clk) begin
		if (pos_we)
			pos_mem[a_in] <= {cmd.pos_x, cmd.pos_y};
		pos_rdata <= pos_mem[pos_raddr];
	end

	always_ff @(posedge clk) begin
		if (frc_we)
			frc_mem[frc_waddr] <= frc_wdata;
		frc_rdata <= frc_mem[frc_raddr];
	end

	// datapath registers
	logic signed [31:0] pax_q, pay_q;
	logic [32:0] ax_q, ay_q;
	logic nx_q, ny_q;
	logic [61:0] sqx_q, sqy_q;
	logic [63:0] sv_q, sres_q, sbit_q;
	logic [31:0] norm_q;
	logic [33:0] remx_q, remy_q;
	logic [QW-1:0] ux_q, uy_q;
	logic signed [31:0] fx_q, fy_q;
	logic [63:0] fsum_q;
	logic [5:0] cnt_q;
	logic res_valid_q;
	gfa_rsp_t res_q;

	// difference vector
	logic signed [32:0] dx, dy;
	logic [32:0] adx, ady;
	logic [32:0] m;
	logic signed [32:0] centre;
	always_comb begin
		centre = 33'($unsigned(area_size_q[30:1]));
		if (state_q == ST_RD_B) begin
			dx = 33'($signed(pos_rdata[63:32])) - 33'(pax_q);
			dy = 33'($signed(pos_rdata[31:0])) - 33'(pay_q);
		end else begin
			dx = centre - 33'($signed(pos_rdata[63:32]));
			dy = centre - 33'($signed(pos_rdata[31:0]));
		end
		adx = dx[32] ? 33'(-dx) : 33'(dx);
		ady = dy[32] ? 33'(-dy) : 33'(dy);
		m = (ax_q > ay_q) ? ax_q : ay_q;
	end

	// sqrt, divide and scale steps
	logic [63:0] rb;
	logic sq_ge, gex, gey;
	logic [30:0] gain;
	logic [PW-1:0] px, py;
	logic [31:0] mx, my;
	always_comb begin
		rb = sres_q + sbit_q;
		sq_ge = sv_q >= rb;
		gex = remx_q >= {2'b00, norm_q};
		gey = remy_q >= {2'b00, norm_q};
		gain = (req_q.mode == OP_EDGE) ? attract_gain_q : gravity_gain_q;
		px = PW'(ux_q) * PW'(gain);
		py = PW'(uy_q) * PW'(gain);
		mx = px[FRAC_BITS +: 32];
		my = py[FRAC_BITS +: 32];
	end

	// saturating accumulate
	logic signed [31:0] add_x, add_y;
	logic signed [32:0] sum_x, sum_y;
	logic signed [31:0] sat_x, sat_y;
	always_comb begin
		add_x = (state_q == ST_FADD_A) ? fx_q : -fx_q;
		add_y = (state_q == ST_FADD_A) ? fy_q : -fy_q;
		sum_x = 33'($signed(frc_rdata[63:32])) + 33'(add_x);
		sum_y = 33'($signed(frc_rdata[31:0])) + 33'(add_y);
		sat_x = (sum_x[32] != sum_x[31]) ? (sum_x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
			: sum_x[31:0];
		sat_y = (sum_y[32] != sum_y[31]) ? (sum_y[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
			: sum_y[31:0];
	end

	logic res_free;
	assign res_free = !res_valid_q || !res_stall;

	gfa_state_t post_state;
	assign post_state = (req_q.mode == OP_EDGE) ? ST_FRD_A : ST_EMIT;

	always_comb begin
		state_d = state_q;
		pos_we = 1'b0;
		frc_we = 1'b0;
		frc_waddr = qa;
		frc_wdata = 64'd0;
		pos_raddr = a_in;
		frc_raddr = a_in;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_acc) begin
					case (gfa_op_t'(cmd.mode))
						OP_LOAD: begin
							if (a_ok) begin
								pos_we = 1'b1;
								frc_we = 1'b1;
								frc_waddr = a_in;
							end
						end
						OP_EDGE: if (a_ok && b_ok) state_d = ST_RD_A;
						OP_READ: if (a_ok) state_d = ST_RD_A;
						default: ;
					endcase
				end
			end
			ST_RD_A: begin
				pos_raddr = qb;
				if (req_q.mode == OP_EDGE)
					state_d = ST_RD_B;
				else if (adx == 33'd0 && ady == 33'd0)
					state_d = post_state;
				else
					state_d = ST_NORM;
			end
			ST_RD_B: begin
				if (adx == 33'd0 && ady == 33'd0)
					state_d = post_state;
				else
					state_d = ST_NORM;
			end
			ST_NORM: if (m < 33'h0_8000_0000 && m[30]) state_d = ST_SQX;
			ST_SQX:  state_d = ST_SQY;
			ST_SQY:  state_d = ST_SUM;
			ST_SUM:  state_d = ST_SQRT;
			ST_SQRT: if (cnt_q == SQRT_STEPS - 6'd1) state_d = ST_DIV;
			ST_DIV:  if (cnt_q == DIV_STEPS) state_d = ST_MUL;
			ST_MUL:  state_d = post_state;
			ST_EMIT: begin
				if (res_free) begin
					frc_we = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_FRD_A: begin
				frc_raddr = qa;
				state_d = ST_FADD_A;
			end
			ST_FADD_A: begin
				frc_we = 1'b1;
				frc_wdata = {sat_x, sat_y};
				state_d = ST_FRD_B;
			end
			ST_FRD_B: begin
				frc_raddr = qb;
				state_d = ST_FADD_B;
			end
			ST_FADD_B: begin
				frc_we = 1'b1;
				frc_waddr = qb;
				frc_wdata = {sat_x, sat_y};
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (cmd_acc)
			req_q <= cmd;
		case (state_q)
			ST_RD_A: begin
				pax_q <= $signed(pos_rdata[63:32]);
				pay_q <= $signed(pos_rdata[31:0]);
				fsum_q <= frc_rdata;
			end
			default: ;
		endcase
		if (state_q == ST_RD_B || (state_q == ST_RD_A && req_q.mode != OP_EDGE)) begin
			ax_q <= adx;
			ay_q <= ady;
			nx_q <= dx[32];
			ny_q <= dy[32];
			fx_q <= 32'sd0;
			fy_q <= 32'sd0;
		end
		if (state_q == ST_NORM) begin
			if (m[32] || m[31]) begin
				ax_q <= ax_q >> 1;
				ay_q <= ay_q >> 1;
			end else if (!m[30]) begin
				ax_q <= ax_q << 1;
				ay_q <= ay_q << 1;
			end
		end
		if (state_q == ST_SQX)
			sqx_q <= 62'(ax_q[30:0]) * 62'(ax_q[30:0]);
		if (state_q == ST_SQY)
			sqy_q <= 62'(ay_q[30:0]) * 62'(ay_q[30:0]);
		if (state_q == ST_SUM) begin
			sv_q <= 64'(sqx_q) + 64'(sqy_q);
			sres_q <= 64'd0;
			sbit_q <= 64'h4000_0000_0000_0000;
			cnt_q <= 6'd0;
		end
		if (state_q == ST_SQRT) begin
			if (sq_ge) begin
				sv_q <= sv_q - rb;
				sres_q <= (sres_q >> 1) + sbit_q;
			end else begin
				sres_q <= sres_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
			cnt_q <= (cnt_q == SQRT_STEPS - 6'd1) ? 6'd0 : cnt_q + 6'd1;
			if (cnt_q == SQRT_STEPS - 6'd1) begin
				norm_q <= sq_ge ? 32'((sres_q >> 1) + sbit_q) : 32'(sres_q >> 1);
				remx_q <= {1'b0, ax_q};
				remy_q <= {1'b0, ay_q};
			end
		end
		if (state_q == ST_DIV && cnt_q != DIV_STEPS) begin
			ux_q <= {ux_q[QW-2:0], gex};
			uy_q <= {uy_q[QW-2:0], gey};
			remx_q <= (gex ? (remx_q - {2'b00, norm_q}) : remx_q) << 1;
			remy_q <= (gey ? (remy_q - {2'b00, norm_q}) : remy_q) << 1;
			cnt_q <= cnt_q + 6'd1;
		end
		if (state_q == ST_MUL) begin
			fx_q <= nx_q ? -$signed(mx) : $signed(mx);
			fy_q <= ny_q ? -$signed(my) : $signed(my);
		end
		if (state_q == ST_EMIT && res_free) begin
			res_q.node_index <= req_q.node_a;
			res_q.gravity_x <= fx_q;
			res_q.gravity_y <= fy_q;
			res_q.attract_x <= $signed(fsum_q[63:32]);
			res_q.attract_y <= $signed(fsum_q[31:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (state_q == ST_EMIT && res_free)
			res_valid_q <= 1'b1;
		else if (!res_stall)
			res_valid_q <= 1'b0;
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	`GFA_ASSERT(a_res_from_emit, clk, arst_n, $rose(res_valid_q) |-> $past(state_q == ST_EMIT))
	`GFA_ASSERT(a_norm_range, clk, arst_n, (state_q == ST_SQX) |-> (m < 33'h0_8000_0000 && m[30]))
	`GFA_NEVER(a_div_by_zero, clk, arst_n, (state_q == ST_DIV) && (norm_q == 32'd0))
	`GFA_NEVER(a_busy_accept, clk, arst_n, (state_q != ST_IDLE) && pos_we)

endmodule
